>>> hw/rtl/ray_box_slab_intersect_assert.svh
// Assertion macros for the ray/box slab test block.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RBS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbs: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RBS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbs: next-cycle check failed");

`endif

>>> hw/rtl/rbs_pkg.sv
// Shared types and constants of the ray/box slab test block.
// No dependencies.
`timescale 1ns / 1ps

package rbs_pkg;

	localparam int FRAC_BITS = 16;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

endpackage

>>> hw/rtl/rbs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Advances on en; used by ray_box_slab_intersect.
`timescale 1ns / 1ps

module rbs_div
	import rbs_pkg::*;
#(
	parameter int NUM_W = 50,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	genvar i;
	generate
		for (i = 0; i < NUM_W; i++) begin : g_stage
			logic [DEN_W-1:0] rem_in;
			logic [NUM_W-1:0] nq_in;
			logic [DEN_W-1:0] den_in;
			logic [DEN_W:0]   trial;
			logic             ge;
			logic [DEN_W:0]   diff;

			if (i == 0) begin : g_first
				assign rem_in = '0;
				assign nq_in  = num;
				assign den_in = den;
			end else begin : g_next
				assign rem_in = rem_s[i-1];
				assign nq_in  = nq_s[i-1];
				assign den_in = den_s[i-1];
			end

			// shift in the next numerator bit, subtract if it fits
			assign trial = {rem_in, nq_in[NUM_W-1]};
			assign ge    = trial >= {1'b0, den_in};
			assign diff  = trial - {1'b0, den_in};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					nq_s[i]  <= {nq_in[NUM_W-2:0], ge};
					den_s[i] <= den_in;
				end
			end
		end
	endgenerate

	assign quo = nq_s[NUM_W-1];

endmodule

>>> hw/rtl/ray_box_slab_intersect.sv
// Top level of the ray/box slab test: one ray against one box per transaction.
// Depends on rbs_pkg, rbs_div and ray_box_slab_intersect_assert.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | origin_*, dir_*, center_*, half_*
//  out     | out_valid / out_ready| hit, distance, point_*, normal_axis/negative
//
// One transaction enters per cycle while the output is not stalled; the pipeline has
// two setup stages, COORD_WIDTH + 18 divider stages and six stages after.
// The six slab divisions, one quotient bit per stage, set the depth.
// arst_n clears only the valid bits; data registers carry no reset.
// A stalled output freezes the whole pipeline; in_ready is low only then.
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_assert.svh"

module ray_box_slab_intersect
	import rbs_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic        [COORD_WIDTH-2:0] half_x,
	input  logic        [COORD_WIDTH-2:0] half_y,
	input  logic        [COORD_WIDTH-2:0] half_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic        [COORD_WIDTH-2:0] distance,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [COORD_WIDTH-1:0] point_z,
	output logic        [1:0]             normal_axis,
	output logic                          normal_negative
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 2;           // slab offset
	localparam int MW = DW + FRAC_BITS;  // numerator / quotient magnitude
	localparam int TW = MW + 1;          // signed distance
	localparam int PW = 2 * W;           // hit point product

	localparam logic signed [TW-1:0] DIST_MAX = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [PW-1:0] ROUND_BIAS = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	typedef struct packed {
		logic [2:0][W-1:0] org;
		logic [2:0][W-1:0] dir;
		logic [2:0][W-1:0] ctr;
		logic [2:0]        dz;
		logic [2:0]        pmiss;
		logic [2:0]        sg_lo;
		logic [2:0]        sg_hi;
	} side_t;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic signed [W-1:0] org_c [3];
	logic signed [W-1:0] dir_c [3];
	logic signed [W-1:0] ctr_c [3];
	logic        [W-2:0] half_c [3];

	assign org_c  = '{origin_x, origin_y, origin_z};
	assign dir_c  = '{dir_x, dir_y, dir_z};
	assign ctr_c  = '{center_x, center_y, center_z};
	assign half_c = '{half_x, half_y, half_z};

	// ---------------- stage 1: slab offsets
	logic              v_s1;
	logic signed [DW-1:0] dlo_s1 [3];
	logic signed [DW-1:0] dhi_s1 [3];
	side_t             sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [DW-1:0] ce, oe, he;
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				ce = {{2{ctr_c[a][W-1]}}, ctr_c[a]};
				oe = {{2{org_c[a][W-1]}}, org_c[a]};
				he = {3'b000, half_c[a]};
				dlo_s1[a]       <= ce - he - oe;
				dhi_s1[a]       <= ce + he - oe;
				sd_s1.org[a]    <= org_c[a];
				sd_s1.dir[a]    <= dir_c[a];
				sd_s1.ctr[a]    <= ctr_c[a];
				sd_s1.dz[a]     <= dir_c[a] == '0;
				// filled in stage 2
				sd_s1.pmiss[a]  <= 1'b0;
				sd_s1.sg_lo[a]  <= 1'b0;
				sd_s1.sg_hi[a]  <= 1'b0;
			end
		end
	end

	// ---------------- stage 2: magnitudes and quotient signs
	logic          v_s2;
	logic [MW-1:0] nlo_s2 [3];
	logic [MW-1:0] nhi_s2 [3];
	logic [W-1:0]  dmag_s2 [3];
	side_t         sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [DW-1:0] ml, mh;
		logic          dn;
		if (en) begin
			sd_s2.org <= sd_s1.org;
			sd_s2.dir <= sd_s1.dir;
			sd_s2.ctr <= sd_s1.ctr;
			sd_s2.dz  <= sd_s1.dz;
			for (int a = 0; a < 3; a++) begin
				ml = dlo_s1[a][DW-1] ? DW'(-dlo_s1[a]) : DW'(dlo_s1[a]);
				mh = dhi_s1[a][DW-1] ? DW'(-dhi_s1[a]) : DW'(dhi_s1[a]);
				dn = sd_s1.dir[a][W-1];
				nlo_s2[a]  <= {ml, {FRAC_BITS{1'b0}}};
				nhi_s2[a]  <= {mh, {FRAC_BITS{1'b0}}};
				dmag_s2[a] <= dn ? W'(-sd_s1.dir[a]) : sd_s1.dir[a];
				sd_s2.sg_lo[a] <= dlo_s1[a][DW-1] ^ dn;
				sd_s2.sg_hi[a] <= dhi_s1[a][DW-1] ^ dn;
				// parallel slab: origin must lie inside the bounds
				sd_s2.pmiss[a] <= sd_s1.dz[a] &&
					((dlo_s1[a] > 0) || dhi_s1[a][DW-1]);
			end
		end
	end

	// ---------------- stage 3: dividers and matching side line
	logic [MW-1:0] qlo [3];
	logic [MW-1:0] qhi [3];
	logic          v_s3 [MW];
	side_t         sd_s3 [MW];

	genvar ga;
	generate
		for (ga = 0; ga < 3; ga++) begin : g_axis
			rbs_div #(.NUM_W(MW), .DEN_W(W)) u_div_lo (
				.clk (clk),
				.en  (en),
				.num (nlo_s2[ga]),
				.den (dmag_s2[ga]),
				.quo (qlo[ga])
			);
			rbs_div #(.NUM_W(MW), .DEN_W(W)) u_div_hi (
				.clk (clk),
				.en  (en),
				.num (nhi_s2[ga]),
				.den (dmag_s2[ga]),
				.quo (qhi[ga])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MW; k++) begin
				v_s3[k] <= 1'b0;
			end
		end else if (en) begin
			v_s3[0] <= v_s2;
			for (int k = 1; k < MW; k++) begin
				v_s3[k] <= v_s3[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3[0] <= sd_s2;
			for (int k = 1; k < MW; k++) begin
				sd_s3[k] <= sd_s3[k-1];
			end
		end
	end

	// ---------------- stage 4: signed near / far per axis
	logic              v_s4;
	logic signed [TW-1:0] near_s4 [3];
	logic signed [TW-1:0] far_s4 [3];
	side_t             sd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3[MW-1];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [TW-1:0] t1, t2;
		if (en) begin
			sd_s4 <= sd_s3[MW-1];
			for (int a = 0; a < 3; a++) begin
				t1 = sd_s3[MW-1].sg_lo[a] ? -$signed({1'b0, qlo[a]}) : $signed({1'b0, qlo[a]});
				t2 = sd_s3[MW-1].sg_hi[a] ? -$signed({1'b0, qhi[a]}) : $signed({1'b0, qhi[a]});
				if (sd_s3[MW-1].dz[a]) begin
					// parallel: leave the interval untouched
					near_s4[a] <= '0;
					far_s4[a]  <= DIST_MAX;
				end else if (t1 > t2) begin
					near_s4[a] <= t2;
					far_s4[a]  <= t1;
				end else begin
					near_s4[a] <= t1;
					far_s4[a]  <= t2;
				end
			end
		end
	end

	// ---------------- stage 5: interval intersection
	logic         v_s5;
	logic         hit_s5;
	logic [W-2:0] tin_s5;
	side_t        sd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [TW-1:0] tin, tout;
		if (en) begin
			tin  = '0;
			tout = DIST_MAX;
			for (int a = 0; a < 3; a++) begin
				if (near_s4[a] > tin) tin = near_s4[a];
				if (far_s4[a] < tout) tout = far_s4[a];
			end
			hit_s5 <= !(|sd_s4.pmiss) && (tin <= tout) && !tout[TW-1];
			tin_s5 <= tin[W-2:0];
			sd_s5  <= sd_s4;
		end
	end

	// ---------------- stage 6: direction times distance
	logic                 v_s6;
	logic                 hit_s6;
	logic [W-2:0]         tin_s6;
	logic signed [PW-1:0] prod_s6 [3];
	side_t                sd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6 <= hit_s5;
			tin_s6 <= tin_s5;
			sd_s6  <= sd_s5;
			for (int a = 0; a < 3; a++) begin
				prod_s6[a] <= $signed(sd_s5.dir[a]) * $signed({1'b0, tin_s5});
			end
		end
	end

	// ---------------- stage 7: scale, add origin, saturate
	logic                v_s7;
	logic                hit_s7;
	logic [W-2:0]        tin_s7;
	logic signed [W-1:0] pt_s7 [3];
	logic [2:0][W-1:0]   ctr_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [PW-1:0] q, s, bias;
		if (en) begin
			hit_s7 <= hit_s6;
			tin_s7 <= tin_s6;
			ctr_s7 <= sd_s6.ctr;
			for (int a = 0; a < 3; a++) begin
				// truncate toward zero
				bias = prod_s6[a][PW-1] ? ROUND_BIAS : '0;
				q = (prod_s6[a] + bias) >>> FRAC_BITS;
				s = q + $signed({{W{sd_s6.org[a][W-1]}}, sd_s6.org[a]});
				if ((&s[PW-1:W-1]) || !(|s[PW-1:W-1])) begin
					pt_s7[a] <= s[W-1:0];
				end else begin
					pt_s7[a] <= s[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
				end
			end
		end
	end

	// ---------------- stage 8: offsets from the center
	logic                v_s8;
	logic                hit_s8;
	logic [W-2:0]        tin_s8;
	logic signed [W-1:0] pt_s8 [3];
	logic [W:0]          mag_s8 [3];
	logic [2:0]          pos_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [W:0] loc;
		if (en) begin
			hit_s8 <= hit_s7;
			tin_s8 <= tin_s7;
			for (int a = 0; a < 3; a++) begin
				loc = $signed({pt_s7[a][W-1], pt_s7[a]}) -
					$signed({ctr_s7[a][W-1], ctr_s7[a]});
				pt_s8[a]  <= pt_s7[a];
				mag_s8[a] <= loc[W] ? (W+1)'(-loc) : (W+1)'(loc);
				pos_s8[a] <= !loc[W] && (loc != '0);
			end
		end
	end

	// ---------------- stage 9: face select, output register
	logic                v_s9;
	logic                hit_s9;
	logic [W-2:0]        dist_s9;
	logic signed [W-1:0] pt_s9 [3];
	axis_t               axis_s9;
	logic                neg_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		axis_t ax;
		if (en) begin
			if (mag_s8[0] > mag_s8[1] && mag_s8[0] > mag_s8[2]) begin
				ax = AXIS_X;
			end else if (mag_s8[1] > mag_s8[2]) begin
				ax = AXIS_Y;
			end else begin
				ax = AXIS_Z;
			end
			hit_s9 <= hit_s8;
			if (hit_s8) begin
				dist_s9 <= tin_s8;
				pt_s9   <= pt_s8;
				axis_s9 <= ax;
				case (ax)
					AXIS_X:  neg_s9 <= !pos_s8[0];
					AXIS_Y:  neg_s9 <= !pos_s8[1];
					default: neg_s9 <= !pos_s8[2];
				endcase
			end else begin
				dist_s9 <= '0;
				pt_s9   <= '{'0, '0, '0};
				axis_s9 <= AXIS_X;
				neg_s9  <= 1'b0;
			end
		end
	end

	assign out_valid       = v_s9;
	assign hit             = hit_s9;
	assign distance        = dist_s9;
	assign point_x         = pt_s9[0];
	assign point_y         = pt_s9[1];
	assign point_z         = pt_s9[2];
	assign normal_axis     = axis_s9;
	assign normal_negative = neg_s9;

	// ---------------- checks
	`RBS_ASSERT_IMP(a_miss_zero, out_valid && !hit, distance == '0 && point_x == '0 && point_y == '0 && point_z == '0 && normal_axis == AXIS_X && !normal_negative)
	`RBS_ASSERT_IMP(a_ready_only_backpressure, !in_ready, out_valid && !out_ready)
	`RBS_ASSERT_NXT(a_accept_enters, in_valid && in_ready, v_s1)

endmodule

>>> bench/ray_box_slab_intersect_tb.sv
// Self-checking bench for ray_box_slab_intersect: directed rows, then random rays.
// Expected results come from a slab-test predictor kept inside the bench or are typed in.
// Depends on rbs_pkg and the ray_box_slab_intersect RTL.
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb
	import rbs_pkg::*;
();

	localparam int CW = 32;
	localparam int LATENCY = CW + 26;
	localparam int N_RANDOM = 680;
	localparam longint DIST_MAX = 64'sh7fff_ffff;
	localparam longint COORD_MAX = 64'sh7fff_ffff;
	localparam longint COORD_MIN = -64'sh8000_0000;

	typedef struct {
		logic signed [CW-1:0] org [3];
		logic signed [CW-1:0] dir [3];
		logic signed [CW-1:0] ctr [3];
		logic        [CW-2:0] half [3];
	} ray_box_t;

	typedef struct {
		logic                 hit;
		logic        [CW-2:0] entry;
		logic signed [CW-1:0] pt [3];
		axis_t                axis;
		logic                 neg;
	} hit_info_t;

	typedef struct {
		ray_box_t  rb;
		bit        typed;
		hit_info_t want;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [CW-1:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
	logic signed [CW-1:0] center_x, center_y, center_z;
	logic        [CW-2:0] half_x, half_y, half_z;
	logic                 hit;
	logic        [CW-2:0] distance;
	logic signed [CW-1:0] point_x, point_y, point_z;
	logic        [1:0]    normal_axis;
	logic                 normal_negative;

	hit_info_t expected_hits [$];
	hit_info_t cur_want;
	int errors = 0, n_sent = 0, n_checked = 0, n_hits = 0;
	int hold_off = 0;
	bit hold_done = 0;

	ray_box_slab_intersect #(.COORD_WIDTH(CW)) i_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic hit_info_t slab_test(ray_box_t rb);
		hit_info_t r;
		longint o, d, lo, hi, t1, t2, s, p;
		longint t_in, t_out;
		longint loc [3];
		longint ax, ay, az;
		bit meets;
		t_in = 0;
		t_out = DIST_MAX;
		meets = 1;
		r.hit = 0;
		r.entry = '0;
		r.axis = AXIS_X;
		r.neg = 0;
		for (int a = 0; a < 3; a++) r.pt[a] = '0;
		for (int a = 0; a < 3 && meets; a++) begin
			o = rb.org[a];
			d = rb.dir[a];
			lo = longint'(rb.ctr[a]) - longint'({1'b0, rb.half[a]});
			hi = longint'(rb.ctr[a]) + longint'({1'b0, rb.half[a]});
			if (d == 0) begin
				if (o < lo || o > hi) meets = 0;
			end else begin
				t1 = ((lo - o) * 65536) / d;
				t2 = ((hi - o) * 65536) / d;
				if (t1 > t2) begin
					s = t1; t1 = t2; t2 = s;
				end
				if (t1 > t_in) t_in = t1;
				if (t2 < t_out) t_out = t2;
				if (t_in > t_out || t_out < 0) meets = 0;
			end
		end
		if (!meets) return r;
		for (int a = 0; a < 3; a++) begin
			p = longint'(rb.org[a]) + (longint'(rb.dir[a]) * t_in) / 65536;
			if (p > COORD_MAX) p = COORD_MAX;
			if (p < COORD_MIN) p = COORD_MIN;
			r.pt[a] = p[CW-1:0];
			loc[a] = p - longint'(rb.ctr[a]);
		end
		ax = loc[0] < 0 ? -loc[0] : loc[0];
		ay = loc[1] < 0 ? -loc[1] : loc[1];
		az = loc[2] < 0 ? -loc[2] : loc[2];
		if (ax > ay && ax > az) r.axis = AXIS_X;
		else if (ay > az) r.axis = AXIS_Y;
		else r.axis = AXIS_Z;
		r.neg = !(loc[r.axis] > 0);
		r.hit = 1;
		r.entry = t_in[CW-2:0];
		return r;
	endfunction

	function automatic ray_box_t mk(longint ox, longint oy, longint oz, longint dx,
			longint dy, longint dz, longint cx, longint cy, longint cz,
			longint hx, longint hy, longint hz);
		ray_box_t rb;
		rb.org = '{ox[CW-1:0], oy[CW-1:0], oz[CW-1:0]};
		rb.dir = '{dx[CW-1:0], dy[CW-1:0], dz[CW-1:0]};
		rb.ctr = '{cx[CW-1:0], cy[CW-1:0], cz[CW-1:0]};
		rb.half = '{hx[CW-2:0], hy[CW-2:0], hz[CW-2:0]};
		return rb;
	endfunction

	function automatic hit_info_t mk_hit(bit h, longint entry, longint px, longint py,
			longint pz, axis_t ax, bit ng);
		hit_info_t r;
		r.hit = h;
		r.entry = entry[CW-2:0];
		r.pt = '{px[CW-1:0], py[CW-1:0], pz[CW-1:0]};
		r.axis = ax;
		r.neg = ng;
		return r;
	endfunction

	function automatic row_t checked_row(ray_box_t rb);
		row_t r;
		r.rb = rb;
		r.typed = 0;
		r.want = mk_hit(0, 0, 0, 0, 0, AXIS_X, 0);
		return r;
	endfunction

	function automatic row_t typed_row(ray_box_t rb, hit_info_t w);
		row_t r;
		r.rb = rb;
		r.typed = 1;
		r.want = w;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rnd_small();
		return $signed(CW'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
	endfunction

	// mostly aimed rays with random content, plus some full-range noise
	function automatic ray_box_t rnd_ray_box();
		ray_box_t rb;
		int mode, sh;
		mode = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++) begin
			rb.org[a] = rnd_small();
			rb.ctr[a] = rnd_small();
			rb.half[a] = (CW-1)'($urandom_range(0, 32'h0004_0000));
			sh = $urandom_range(0, 6);
			rb.dir[a] = (rb.ctr[a] - rb.org[a]) >>> sh;
			if ($urandom_range(0, 7) == 0) rb.dir[a] = '0;
			if (mode >= 7) begin
				rb.org[a] = $urandom;
				rb.dir[a] = $urandom;
				rb.ctr[a] = $urandom;
				rb.half[a] = (CW-1)'($urandom);
			end else if (mode == 6) begin
				rb.dir[a] = rnd_small();
			end
		end
		return rb;
	endfunction

	task automatic send(ray_box_t rb, bit typed, hit_info_t want);
		@(negedge clk);
		{origin_x, origin_y, origin_z} = {rb.org[0], rb.org[1], rb.org[2]};
		{dir_x, dir_y, dir_z} = {rb.dir[0], rb.dir[1], rb.dir[2]};
		{center_x, center_y, center_z} = {rb.ctr[0], rb.ctr[1], rb.ctr[2]};
		{half_x, half_y, half_z} = {rb.half[0], rb.half[1], rb.half[2]};
		cur_want = typed ? want : slab_test(rb);
		in_valid = 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// record the expectation at the accepting edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_hits = {expected_hits, cur_want};
			n_sent++;
		end
	end

	task automatic report(string what, longint want, longint got);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		hit_info_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				$display("%0t: unexpected transaction at output", $time);
				errors++;
			end else begin
				w = expected_hits.pop_front();
				n_checked++;
				if (hit) n_hits++;
				if (hit !== w.hit) report("hit", w.hit, hit);
				if (distance !== w.entry) report("distance", w.entry, distance);
				if (point_x !== w.pt[0]) report("point_x", w.pt[0], point_x);
				if (point_y !== w.pt[1]) report("point_y", w.pt[1], point_y);
				if (point_z !== w.pt[2]) report("point_z", w.pt[2], point_z);
				if (normal_axis !== w.axis) report("normal_axis", w.axis, normal_axis);
				if (normal_negative !== w.neg)
					report("normal_negative", w.neg, normal_negative);
			end
		end
	end

	// receiver: own stall pattern, one long hold-off to back the pipe up
	initial begin
		int mode;
		out_ready = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && n_sent >= 250) begin
				hold_done = 1;
				hold_off = 200;
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready = 0;
			end else begin
				if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: out_ready = 1;
					1: out_ready = $urandom_range(0, 3) != 0;
					default: out_ready = $urandom_range(0, 1);
				endcase
			end
		end
	end

	initial begin
		row_t rows [$];
		int gap, burst, wait_cnt;
		in_valid = 0;
		{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
		{center_x, center_y, center_z, half_x, half_y, half_z} = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// degenerate ray at the box center: every offset is zero, ties go to z
		rows = {rows, typed_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			mk_hit(1, 0, 0, 0, 0, AXIS_Z, 1))};
		// ray along +x into a box at x=10, enters the -x face at t=9
		rows = {rows, typed_row(mk(0, 0, 0, 65536, 0, 0, 655360, 0, 0, 65536, 65536, 65536),
			mk_hit(1, 589824, 589824, 0, 0, AXIS_X, 1))};
		// parallel on y, origin outside the slab
		rows = {rows, typed_row(mk(0, 5 << 16, 0, 65536, 0, 0, 0, 0, 0, 65536, 65536, 65536),
			mk_hit(0, 0, 0, 0, 0, AXIS_X, 0))};
		// box behind the ray
		rows = {rows, typed_row(mk(0, 0, 0, -65536, 0, 0, 655360, 0, 0, 65536, 65536, 65536),
			mk_hit(0, 0, 0, 0, 0, AXIS_X, 0))};
		// extremes and saturation
		rows = {rows, checked_row(mk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, DIST_MAX, DIST_MAX, DIST_MAX))};
		rows = {rows, checked_row(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, DIST_MAX, DIST_MAX, DIST_MAX))};
		rows = {rows, checked_row(mk(0, 0, 0, 1, 1, 1, 0, 0, 0, DIST_MAX, DIST_MAX,
			DIST_MAX))};
		rows = {rows, checked_row(mk(0, 0, 0, -1, -1, -1, 0, 0, 0, DIST_MAX, DIST_MAX,
			DIST_MAX))};
		rows = {rows, checked_row(mk(COORD_MIN, 0, 0, COORD_MAX, 0, 0, 0, 0, 0, 1, 1, 1))};
		// entry beyond the largest distance is a miss
		rows = {rows, checked_row(mk(0, 0, 0, 1, 0, 0, COORD_MAX, 0, 0, 0, 0, 0))};
		rows = {rows, checked_row(mk(-1, -1, -1, 1, 1, 1, 0, 0, 0, 0, 0, 0))};
		// grazing an edge: distances tie, normal tie-break on y and z
		rows = {rows, checked_row(mk(-2 << 16, -2 << 16, 0, 65536, 65536, 0, 0, 0, 0,
			65536, 65536, 65536))};
		rows = {rows, checked_row(mk(0, -2 << 16, -2 << 16, 0, 65536, 65536, 0, 0, 0,
			65536, 65536, 65536))};
		rows = {rows, checked_row(mk(3 << 16, 0, 0, -65536, 0, 0, 0, 0, 0, 65536, 65536,
			65536))};
		rows = {rows, checked_row(mk(0, 0, 3 << 16, 0, 0, -65536, 0, 0, 0, 65536, 65536,
			65536))};
		// origin inside the box
		rows = {rows, checked_row(mk(100, -100, 7, 3, -5, 11, 0, 0, 0, 65536, 65536,
			65536))};

		foreach (rows[i]) send(rows[i].rb, rows[i].typed, rows[i].want);

		burst = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					@(negedge clk);
					in_valid = 0;
					repeat (gap - 1) @(negedge clk);
				end
			end
			burst--;
			send(rnd_ray_box(), 0, cur_want);
		end
		@(negedge clk);
		in_valid = 0;

		wait_cnt = 0;
		while (expected_hits.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (LATENCY + 20) @(posedge clk);
		if (expected_hits.size() != 0) begin
			$display("%0d expected transactions never arrived", expected_hits.size());
			errors++;
		end
		$display("Covered %0d transactions (%0d hits), directed edge cases, random bursts",
			n_checked, n_hits);
		$display("and one long output stall; %0d mismatches", errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
